FILE: rtl/core/acds_pkg.sv
// ----------------------------------------------------------------------------
// acds_pkg
// Shared types, constants and helpers for the alarm clock with display scan.
// ----------------------------------------------------------------------------
package acds_pkg;

	// Function codes on the input channel
	localparam logic [1:0] FUNC_TICK    = 2'd0;
	localparam logic [1:0] FUNC_REFRESH = 2'd1;
	localparam logic [1:0] FUNC_BUTTON  = 2'd2;

	// Button bit positions
	localparam int BTN_MODE    = 0;
	localparam int BTN_CONFIRM = 1;
	localparam int BTN_HOUR    = 2;
	localparam int BTN_MINUTE  = 3;

	// Time limits
	localparam logic [5:0] SEC_PER_MIN   = 6'd60;
	localparam logic [5:0] MIN_PER_HOUR  = 6'd60;
	localparam logic [4:0] HOURS_PER_DAY = 5'd24;
	localparam logic [4:0] LAST_HOUR     = 5'd23;
	localparam logic [5:0] LAST_MIN      = 6'd59;
	localparam logic [5:0] LAST_SEC      = 6'd59;
	localparam logic [3:0] MAX_DIGIT     = 4'd9;

	// Reset values of the clock state
	localparam logic [4:0] RST_HOUR       = 5'd13;
	localparam logic [5:0] RST_MINUTE     = 6'd22;
	localparam logic [5:0] RST_SECOND     = 6'd30;
	localparam logic [4:0] RST_ALARM_HOUR = 5'd13;
	localparam logic [5:0] RST_ALARM_MIN  = 6'd23;

	// Event queue depth (power of two)
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		EV_TICK,
		EV_REFRESH,
		EV_BUTTON,
		EV_NONE
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t   kind;
		logic [3:0] buttons;
	} ev_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Grid and segment words, one row per digit position
	localparam logic [23:0] SEG_TABLE [4][10] = '{
		'{24'h0101dd, 24'h010090, 24'h010156, 24'h010196, 24'h01009a,
		  24'h01018e, 24'h0101ce, 24'h010094, 24'h0101df, 24'h01019f},
		'{24'h0081fd, 24'h0080b0, 24'h008176, 24'h0081b6, 24'h0080ba,
		  24'h0081ae, 24'h0081ee, 24'h0080b4, 24'h0081ff, 24'h0081bf},
		'{24'h0005dd, 24'h000490, 24'h000556, 24'h000596, 24'h00049a,
		  24'h00058e, 24'h0005ce, 24'h000494, 24'h0005df, 24'h00059f},
		'{24'h0009dd, 24'h000890, 24'h000956, 24'h000996, 24'h00089a,
		  24'h00098e, 24'h0009ce, 24'h000894, 24'h0009df, 24'h00099f}
	};

	// Tens digit of a 6-bit value by compare chain
	function automatic logic [2:0] tens_of(input logic [5:0] v);
		logic [2:0] t;
		if (v >= 6'd60)      t = 3'd6;
		else if (v >= 6'd50) t = 3'd5;
		else if (v >= 6'd40) t = 3'd4;
		else if (v >= 6'd30) t = 3'd3;
		else if (v >= 6'd20) t = 3'd2;
		else if (v >= 6'd10) t = 3'd1;
		else                 t = 3'd0;
		return t;
	endfunction

	// Units digit of a 6-bit value
	function automatic logic [3:0] units_of(input logic [5:0] v);
		logic [5:0] r;
		r = v - 6'({3'd0, tens_of(v)} * 6'd10);
		return r[3:0];
	endfunction

	// Look up the word for one digit position, clamping the digit to nine
	function automatic logic [23:0] seg_word(input logic [1:0] phase,
	                                         input logic [3:0] digit);
		logic [3:0] d;
		d = (digit > MAX_DIGIT) ? MAX_DIGIT : digit;
		return SEG_TABLE[phase][d];
	endfunction

	// Add one and wrap at the modulus
	function automatic logic [5:0] bump(input logic [5:0] v, input logic [5:0] modulus);
		logic [6:0] s;
		s = {1'b0, v} + 7'd1;
		return (s >= {1'b0, modulus}) ? 6'd0 : s[5:0];
	endfunction

endpackage

FILE: rtl/core/acds_front.sv
// ----------------------------------------------------------------------------
// acds_front
// Input stage: accepts events, classifies the function code, feeds the queue.
// ----------------------------------------------------------------------------
module acds_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          func,
	input  logic [3:0]          buttons_low,
	input  acds_pkg::q_status_t q_status,
	output logic                push,
	output acds_pkg::ev_t       push_ev
);
	import acds_pkg::*;

	logic valid_s1;
	ev_t  ev_s1;
	ev_t  ev_class;

	// Classify the function code
	always_comb begin
		ev_class.buttons = buttons_low;
		case (func)
			FUNC_TICK:    ev_class.kind = EV_TICK;
			FUNC_REFRESH: ev_class.kind = EV_REFRESH;
			FUNC_BUTTON:  ev_class.kind = EV_BUTTON;
			default:      ev_class.kind = EV_NONE;
		endcase
	end

	// Hold the stage while the queue is full
	assign in_stall = valid_s1 && q_status.full;
	assign push     = valid_s1 && !q_status.full;
	assign push_ev  = ev_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ev_s1 <= ev_class;
		end
	end

endmodule

FILE: rtl/core/acds_queue.sv
// ----------------------------------------------------------------------------
// acds_queue
// Short event queue between the input stage and the execute stage.
// ----------------------------------------------------------------------------
module acds_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  acds_pkg::ev_t       push_ev,
	input  logic                pop,
	output acds_pkg::ev_t       pop_ev,
	output acds_pkg::q_status_t q_status
);
	import acds_pkg::*;

	ev_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign q_status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_status.empty = (count_q == '0);
	assign pop_ev         = mem_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Store the pushed event
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_ev;
		end
	end

endmodule

FILE: rtl/core/acds_back.sv
// ----------------------------------------------------------------------------
// acds_back
// Execute stage: keeps time, alarm and display state, registers each result.
// ----------------------------------------------------------------------------
module acds_back (
	input  logic                clk,
	input  logic                arst_n,
	input  acds_pkg::q_status_t q_status,
	input  acds_pkg::ev_t       pop_ev,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [23:0]         segment_word,
	output logic                strobe_res,
	output logic                led_out,
	output logic                alarm_sound,
	output logic [4:0]          show_hours,
	output logic [5:0]          show_minutes,
	output logic [5:0]          show_seconds,
	output logic                setting_alarm,
	output logic                alarm_armed
);
	import acds_pkg::*;

	// Clock state
	logic [4:0] hour_q, alarm_hour_q;
	logic [5:0] min_q, sec_q, alarm_min_q;
	logic       half_q, edit_q, armed_q, lamps_q, led_q;
	logic [1:0] phase_q;

	// Next state
	logic [4:0]  nx_hour, nx_alarm_hour;
	logic [5:0]  nx_min, nx_sec, nx_alarm_min;
	logic        nx_half, nx_edit, nx_armed, nx_lamps, nx_led;
	logic [1:0]  nx_phase;
	logic [23:0] nx_word;
	logic        nx_strobe;
	logic [5:0]  disp_h, disp_m;
	logic [3:0]  digit;

	// Take the next event when the output register is free or draining
	assign pop = !q_status.empty && (!out_valid || !out_stall);

	always_comb begin
		nx_hour       = hour_q;
		nx_min        = min_q;
		nx_sec        = sec_q;
		nx_alarm_hour = alarm_hour_q;
		nx_alarm_min  = alarm_min_q;
		nx_half       = half_q;
		nx_edit       = edit_q;
		nx_armed      = armed_q;
		nx_lamps      = lamps_q;
		nx_led        = led_q;
		nx_phase      = phase_q;
		nx_word       = '0;
		nx_strobe     = 1'b0;
		disp_h        = edit_q ? {1'b0, alarm_hour_q} : {1'b0, hour_q};
		disp_m        = edit_q ? alarm_min_q : min_q;
		case (phase_q)
			2'd0:    digit = {1'b0, tens_of(disp_h)};
			2'd1:    digit = units_of(disp_h);
			2'd2:    digit = {1'b0, tens_of(disp_m)};
			default: digit = units_of(disp_m);
		endcase

		case (pop_ev.kind)
			// Half-second tick: count, carry, blink
			EV_TICK: begin
				nx_led  = armed_q;
				nx_half = ~half_q;
				nx_sec  = sec_q + 6'(half_q);
				if (edit_q) begin
					nx_lamps = ~lamps_q;
				end
				if (nx_sec >= SEC_PER_MIN) begin
					nx_sec = '0;
					nx_min = min_q + 6'd1;
				end
				if (nx_min >= MIN_PER_HOUR) begin
					nx_min  = '0;
					nx_hour = hour_q + 5'd1;
				end
				if (nx_hour >= HOURS_PER_DAY) begin
					nx_hour = '0;
				end
				if (nx_hour == LAST_HOUR && nx_min == LAST_MIN && nx_sec == LAST_SEC) begin
					nx_hour = '0;
					nx_min  = '0;
					nx_sec  = '0;
				end
			end
			// Refresh tick: strobe, and while lit emit one digit and advance the scan
			EV_REFRESH: begin
				nx_strobe = 1'b1;
				if (lamps_q) begin
					nx_word  = seg_word(phase_q, digit);
					nx_phase = phase_q + 2'd1;
				end
			end
			// Button change: mode, confirm, hour up, minute up in order
			EV_BUTTON: begin
				if (pop_ev.buttons[BTN_MODE]) begin
					if (armed_q) begin
						nx_armed = 1'b0;
						nx_edit  = 1'b0;
					end else begin
						nx_edit = 1'b1;
					end
				end
				if (pop_ev.buttons[BTN_CONFIRM] && nx_edit) begin
					nx_armed = 1'b1;
					nx_edit  = 1'b0;
					nx_lamps = 1'b1;
				end
				if (pop_ev.buttons[BTN_HOUR]) begin
					if (nx_edit) begin
						nx_alarm_hour = 5'(bump({1'b0, alarm_hour_q}, {1'b0, HOURS_PER_DAY}));
					end else begin
						nx_hour = 5'(bump({1'b0, hour_q}, {1'b0, HOURS_PER_DAY}));
					end
				end
				if (pop_ev.buttons[BTN_MINUTE]) begin
					if (nx_edit) begin
						nx_alarm_min = bump(alarm_min_q, MIN_PER_HOUR);
					end else begin
						nx_min = bump(min_q, MIN_PER_HOUR);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Update state on each executed event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_q       <= RST_HOUR;
			min_q        <= RST_MINUTE;
			sec_q        <= RST_SECOND;
			alarm_hour_q <= RST_ALARM_HOUR;
			alarm_min_q  <= RST_ALARM_MIN;
			half_q       <= 1'b0;
			edit_q       <= 1'b0;
			armed_q      <= 1'b0;
			lamps_q      <= 1'b1;
			phase_q      <= 2'd0;
			led_q        <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			if (pop) begin
				hour_q       <= nx_hour;
				min_q        <= nx_min;
				sec_q        <= nx_sec;
				alarm_hour_q <= nx_alarm_hour;
				alarm_min_q  <= nx_alarm_min;
				half_q       <= nx_half;
				edit_q       <= nx_edit;
				armed_q      <= nx_armed;
				lamps_q      <= nx_lamps;
				phase_q      <= nx_phase;
				led_q        <= nx_led;
				out_valid    <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Register the result transfer
	always_ff @(posedge clk) begin
		if (pop) begin
			segment_word  <= nx_word;
			strobe_res    <= nx_strobe;
			led_out       <= nx_led;
			alarm_sound   <= nx_armed && !nx_edit && nx_hour == nx_alarm_hour &&
			                 nx_min == nx_alarm_min;
			show_hours    <= nx_hour;
			show_minutes  <= nx_min;
			show_seconds  <= nx_sec;
			setting_alarm <= nx_edit;
			alarm_armed   <= nx_armed;
		end
	end

endmodule

FILE: rtl/core/alarm_clock_with_display_scan_unit.sv
// ----------------------------------------------------------------------------
// alarm_clock_with_display_scan_unit
// 24-hour alarm clock with a four-digit multiplexed display word generator.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one event per transfer: func
// selects a half-second tick, a display refresh tick or a button change, and
// buttons_low holds the pressed buttons for a button change.
// Output channel (out_valid/out_stall) returns exactly one result per event:
// the digit word and strobe for a refresh tick, plus the time, alarm flags
// and lamp level after the event.
// After an input transfer the event is loaded into the input stage, then
// written into the event queue, then run by the execute stage, which loads
// the output register and raises out_valid. Throughput is one event per
// cycle while the receiver does not stall, set by the execute stage.
// When the receiver stalls, the output register holds its result, the
// two-entry queue fills, then the input stage holds and raises in_stall.
// Reset sets the clock to 13:22:30, the alarm to 13:23, disarmed, display
// lit and scanning from the hour-tens digit; all channels come up empty.
// ----------------------------------------------------------------------------
module alarm_clock_with_display_scan_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [3:0]  buttons_low,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [23:0] segment_word,
	output logic        strobe_res,
	output logic        led_out,
	output logic        alarm_sound,
	output logic [4:0]  show_hours,
	output logic [5:0]  show_minutes,
	output logic [5:0]  show_seconds,
	output logic        setting_alarm,
	output logic        alarm_armed
);
	import acds_pkg::*;

	q_status_t q_status;
	logic      push;
	logic      pop;
	ev_t       push_ev;
	ev_t       pop_ev;

	acds_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.buttons_low(buttons_low),
		.q_status   (q_status),
		.push       (push),
		.push_ev    (push_ev)
	);

	acds_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_ev (push_ev),
		.pop     (pop),
		.pop_ev  (pop_ev),
		.q_status(q_status)
	);

	acds_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_status     (q_status),
		.pop_ev       (pop_ev),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.segment_word (segment_word),
		.strobe_res   (strobe_res),
		.led_out      (led_out),
		.alarm_sound  (alarm_sound),
		.show_hours   (show_hours),
		.show_minutes (show_minutes),
		.show_seconds (show_seconds),
		.setting_alarm(setting_alarm),
		.alarm_armed  (alarm_armed)
	);

	// Time fields stay in range
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (show_hours < HOURS_PER_DAY && show_minutes < MIN_PER_HOUR &&
		               show_seconds < SEC_PER_MIN))
		else $error("time field out of range");

	// Only a refresh result carries a digit word
	a_word_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !strobe_res) |-> (segment_word == '0))
		else $error("digit word without strobe");

	// No alarm while the alarm time is being edited
	a_quiet_edit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && setting_alarm) |-> !alarm_sound)
		else $error("alarm sounds while editing");

	// Queue is never both full and empty, and never pops when empty
	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty) && !(pop && q_status.empty))
		else $error("queue status inconsistent");

endmodule
